FILE: rtl/pkfilt_pkg.sv
// Shared types and constants of the port-knock frame filter.
`default_nettype none
package pkfilt_pkg;

   localparam int POS_W = 7;
   localparam logic [POS_W-1:0] POS_MAX = 7'd127;
   localparam logic [POS_W-1:0] ETH_HDR_BYTES = 7'd14;
   localparam logic [POS_W-1:0] POS_ETYPE_HI = 7'd12;
   localparam logic [POS_W-1:0] POS_ETYPE_LO = 7'd13;
   localparam logic [POS_W-1:0] POS_IHL = 7'd14;
   localparam logic [POS_W-1:0] POS_PROTO = 7'd23;
   localparam logic [POS_W-1:0] POS_SRC_FIRST = 7'd26;
   localparam logic [POS_W-1:0] POS_SRC_LAST = 7'd29;
   localparam logic [POS_W-1:0] POS_IP_LAST = 7'd33;
   localparam logic [POS_W-1:0] OFS_DPORT_HI = 7'd2;
   localparam logic [POS_W-1:0] OFS_DPORT_LO = 7'd3;
   localparam logic [POS_W-1:0] OFS_TCP_FLAGS = 7'd13;
   localparam logic [POS_W-1:0] OFS_TCP_LAST = 7'd19;
   localparam logic [POS_W-1:0] OFS_UDP_LAST = 7'd7;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam int FLAG_SYN_BIT = 1;
   localparam int FLAG_ACK_BIT = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int COUNT_W = 3;
   localparam int REG_PORTS = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOCK_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_BASE = 3'd1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        eligible;
      logic        udp;
      logic [15:0] port;
      logic [31:0] source;
   } frame_summary_type;

endpackage
`default_nettype wire

FILE: rtl/pkfilt_if.sv
// Channel interfaces of the port-knock frame filter: frame bytes, results and register writes.
`default_nettype none
interface pkfilt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       end_of_frame;
   modport source (output valid, output frame_byte, output end_of_frame, input ready);
   modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface pkfilt_rsp_if;
   logic        valid;
   logic        ready;
   logic        knock_found;
   logic [31:0] source_address;
   logic [15:0] knock_port;
   logic        over_udp;
   modport source (output valid, output knock_found, output source_address,
                   output knock_port, output over_udp, input ready);
   modport sink (input valid, input knock_found, input source_address,
                 input knock_port, input over_udp, output ready);
endinterface

interface pkfilt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [pkfilt_pkg::CSR_INDEX_W-1:0] wr_index;
   logic [pkfilt_pkg::CSR_DATA_W-1:0]  wr_data;
   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink (input valid, input wr_index, input wr_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pkfilt_front.sv
// Front end: parses frame bytes and emits one summary per frame.
`default_nettype none
module pkfilt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pkfilt_req_if.sink                         req_bus,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output pkfilt_pkg::frame_summary_type      push_data
);

   logic [pkfilt_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0] ether_type_ff, ether_type_in, ether_type_new;
   logic [3:0]  header_words_ff, header_words_in, header_words_new;
   logic [7:0]  ip_protocol_ff, ip_protocol_in, ip_protocol_new;
   logic [31:0] source_ff, source_in, source_new;
   logic [15:0] dest_port_ff, dest_port_in, dest_port_new;
   logic [7:0]  tcp_flags_ff, tcp_flags_in, tcp_flags_new;
   logic [pkfilt_pkg::POS_W-1:0] t_base;
   logic        accept;
   logic        last;
   logic [7:0]  b;
   logic        tcp_ok;
   logic        udp_ok;

   assign req_bus.ready = push_ready;
   assign accept = req_bus.valid && req_bus.ready;
   assign last = req_bus.end_of_frame;
   assign b = req_bus.frame_byte;
   assign t_base = pkfilt_pkg::ETH_HDR_BYTES + {1'b0, header_words_ff, 2'b00};

   always_comb begin
      ether_type_new = ether_type_ff;
      header_words_new = header_words_ff;
      ip_protocol_new = ip_protocol_ff;
      source_new = source_ff;
      dest_port_new = dest_port_ff;
      tcp_flags_new = tcp_flags_ff;
      if (pos_ff == pkfilt_pkg::POS_ETYPE_HI) begin
         ether_type_new = {b, 8'h00};
      end else if (pos_ff == pkfilt_pkg::POS_ETYPE_LO) begin
         ether_type_new = {ether_type_ff[15:8], b};
      end else if (pos_ff == pkfilt_pkg::POS_IHL) begin
         header_words_new = b[3:0];
      end else if (pos_ff == pkfilt_pkg::POS_PROTO) begin
         ip_protocol_new = b;
      end else if (pos_ff >= pkfilt_pkg::POS_SRC_FIRST && pos_ff <= pkfilt_pkg::POS_SRC_LAST) begin
         source_new = {source_ff[23:0], b};
      end
      if (pos_ff > pkfilt_pkg::ETH_HDR_BYTES) begin
         if (pos_ff == t_base + pkfilt_pkg::OFS_DPORT_HI) begin
            dest_port_new = {b, 8'h00};
         end else if (pos_ff == t_base + pkfilt_pkg::OFS_DPORT_LO) begin
            dest_port_new = {dest_port_ff[15:8], b};
         end else if (pos_ff == t_base + pkfilt_pkg::OFS_TCP_FLAGS) begin
            tcp_flags_new = b;
         end
      end
   end

   always_comb begin
      tcp_ok = (ip_protocol_new == pkfilt_pkg::PROTO_TCP)
            && (pos_ff >= t_base + pkfilt_pkg::OFS_TCP_LAST)
            && tcp_flags_new[pkfilt_pkg::FLAG_SYN_BIT]
            && !tcp_flags_new[pkfilt_pkg::FLAG_ACK_BIT];
      udp_ok = (ip_protocol_new == pkfilt_pkg::PROTO_UDP)
            && (pos_ff >= t_base + pkfilt_pkg::OFS_UDP_LAST);
      push_data.eligible = (ether_type_new == pkfilt_pkg::ETYPE_IPV4)
                        && (pos_ff >= pkfilt_pkg::POS_IP_LAST) && (tcp_ok || udp_ok);
      push_data.udp = (ip_protocol_new == pkfilt_pkg::PROTO_UDP);
      push_data.port = dest_port_new;
      push_data.source = source_new;
   end

   assign push_valid = accept && last;

   always_comb begin
      pos_in = pos_ff;
      ether_type_in = ether_type_ff;
      header_words_in = header_words_ff;
      ip_protocol_in = ip_protocol_ff;
      source_in = source_ff;
      dest_port_in = dest_port_ff;
      tcp_flags_in = tcp_flags_ff;
      if (accept) begin
         if (last) begin
            pos_in = '0;
            ether_type_in = '0;
            header_words_in = '0;
            ip_protocol_in = '0;
            source_in = '0;
            dest_port_in = '0;
            tcp_flags_in = '0;
         end else begin
            pos_in = (pos_ff < pkfilt_pkg::POS_MAX) ? pos_ff + 7'd1 : pos_ff;
            ether_type_in = ether_type_new;
            header_words_in = header_words_new;
            ip_protocol_in = ip_protocol_new;
            source_in = source_new;
            dest_port_in = dest_port_new;
            tcp_flags_in = tcp_flags_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ether_type_ff <= '0;
         header_words_ff <= '0;
         ip_protocol_ff <= '0;
         source_ff <= '0;
         dest_port_ff <= '0;
         tcp_flags_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ether_type_ff <= ether_type_in;
         header_words_ff <= header_words_in;
         ip_protocol_ff <= ip_protocol_in;
         source_ff <= source_in;
         dest_port_ff <= dest_port_in;
         tcp_flags_ff <= tcp_flags_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/pkfilt_queue.sv
// Short queue of frame summaries between the front and back ends.
`default_nettype none
module pkfilt_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire pkfilt_pkg::frame_summary_type in_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output pkfilt_pkg::frame_summary_type      out_data
);

   pkfilt_pkg::frame_summary_type entry_ff [pkfilt_pkg::QUEUE_DEPTH];
   logic [pkfilt_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pkfilt_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pkfilt_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign in_ready = (count_ff < pkfilt_pkg::QCNT_W'(pkfilt_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data = entry_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pkfilt_pkg::QPTR_W'(pkfilt_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pkfilt_pkg::QPTR_W'(pkfilt_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/pkfilt_back.sv
// Back end: knock port registers, port match and the result output register.
`default_nettype none
module pkfilt_back #(
   parameter int PORT_SLOTS = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pkfilt_csr_if.sink                         csr_bus,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire pkfilt_pkg::frame_summary_type pop_data,
   pkfilt_rsp_if.source                       rsp_bus
);

   logic [pkfilt_pkg::COUNT_W-1:0] knock_count_ff;
   logic [15:0] knock_ports_ff [PORT_SLOTS];
   logic        listed;
   logic        found;
   logic        csr_write;
   logic        out_valid_ff, out_valid_in;
   logic        found_ff;
   logic [31:0] source_ff;
   logic [15:0] port_ff;
   logic        udp_ff;
   logic        take;

   assign csr_bus.ready = 1'b1;
   assign csr_write = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         knock_count_ff <= '0;
         for (int i = 0; i < PORT_SLOTS; i++) begin
            knock_ports_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_bus.wr_index == pkfilt_pkg::CSR_KNOCK_COUNT) begin
            knock_count_ff <= csr_bus.wr_data[pkfilt_pkg::COUNT_W-1:0];
         end
         for (int i = 0; i < PORT_SLOTS; i++) begin
            if (csr_bus.wr_index == pkfilt_pkg::CSR_PORT_BASE + pkfilt_pkg::CSR_INDEX_W'(i)) begin
               knock_ports_ff[i] <= csr_bus.wr_data;
            end
         end
      end
   end

   always_comb begin
      listed = 1'b0;
      for (int i = 0; i < PORT_SLOTS; i++) begin
         if (knock_count_ff > pkfilt_pkg::COUNT_W'(i) && knock_ports_ff[i] == pop_data.port) begin
            listed = 1'b1;
         end
      end
   end

   assign found = pop_data.eligible && listed;
   assign pop_ready = !out_valid_ff || rsp_bus.ready;
   assign take = pop_valid && pop_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         found_ff <= found;
         source_ff <= found ? pop_data.source : '0;
         port_ff <= found ? pop_data.port : '0;
         udp_ff <= found && pop_data.udp;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.knock_found = found_ff;
   assign rsp_bus.source_address = source_ff;
   assign rsp_bus.knock_port = port_ff;
   assign rsp_bus.over_udp = udp_ff;

endmodule
`default_nettype wire

FILE: rtl/port_knock_frame_filter_core.sv
// Top level of the port-knock frame filter: front end, summary queue and back end.
//
// Frame bytes enter on req_bus, one transaction per byte, with end_of_frame set on
// the last byte. Each frame produces exactly one transaction on rsp_bus, carrying
// knock_found and, for a knock, the IPv4 source address, destination port and a
// UDP marker; all of these are zero when the frame is not a knock.
// Register writes arrive on csr_bus: index 0 sets the number of ports in use,
// indices 1 to 6 set the ports, and other indices are dropped. csr_bus is always ready.
// The front end takes one byte per cycle while the queue has room and parses the
// frame as it streams. The summary of a frame passes through the queue and then
// the output register. A two-entry queue and the output register let the front
// end keep taking bytes while a result waits; req_bus.ready drops only when the
// queue is full, which needs the receiver to stall across several frame ends.
// Reset is synchronous and clears the parser, the queue, the output valid flag
// and all knock registers; the block accepts bytes as soon as reset is released.
`default_nettype none
module port_knock_frame_filter_core #(
   parameter int PORT_SLOTS = 6
) (
   input  wire logic    clock,
   input  wire logic    reset,
   pkfilt_req_if.sink   req_bus,
   pkfilt_rsp_if.source rsp_bus,
   pkfilt_csr_if.sink   csr_bus
);

   logic                          q_in_valid;
   logic                          q_in_ready;
   pkfilt_pkg::frame_summary_type q_in_data;
   logic                          q_out_valid;
   logic                          q_out_ready;
   pkfilt_pkg::frame_summary_type q_out_data;

   pkfilt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_data  (q_in_data)
   );

   pkfilt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   pkfilt_back #(
      .PORT_SLOTS (PORT_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_bus   (csr_bus),
      .pop_valid (q_out_valid),
      .pop_ready (q_out_ready),
      .pop_data  (q_out_data),
      .rsp_bus   (rsp_bus)
   );

   // A byte that ends a frame leaves a summary waiting in the queue.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.end_of_frame) |=> q_out_valid)
      else $error("frame end did not reach the queue");

   // Only the last byte of a frame pushes a summary.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && !req_bus.end_of_frame) |-> !q_in_valid)
      else $error("summary pushed in the middle of a frame");

   // A summary taken from the queue is presented on the result channel next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (q_out_valid && q_out_ready) |=> rsp_bus.valid)
      else $error("popped summary did not reach the output");

endmodule
`default_nettype wire
